// ===== hw/rtl/sia_pkg.sv =====
`default_nettype none
package sia_pkg;

	localparam int Width = 32;
	localparam int ShW = $clog2(Width);

	localparam logic [4:0] FN_LT       = 5'd0;
	localparam logic [4:0] FN_ODD      = 5'd1;
	localparam logic [4:0] FN_EVEN     = 5'd2;
	localparam logic [4:0] FN_ZERO     = 5'd3;
	localparam logic [4:0] FN_POS      = 5'd4;
	localparam logic [4:0] FN_NEG      = 5'd5;
	localparam logic [4:0] FN_ABS      = 5'd6;
	localparam logic [4:0] FN_NEGATE   = 5'd7;
	localparam logic [4:0] FN_ADD      = 5'd8;
	localparam logic [4:0] FN_SUB      = 5'd9;
	localparam logic [4:0] FN_MUL      = 5'd10;
	localparam logic [4:0] FN_DIV      = 5'd11;
	localparam logic [4:0] FN_MOD      = 5'd12;
	localparam logic [4:0] FN_REM      = 5'd13;
	localparam logic [4:0] FN_TRUNCDIV = 5'd14;
	localparam logic [4:0] FN_QUOTIENT = 5'd15;
	localparam logic [4:0] FN_ASH      = 5'd16;
	localparam logic [4:0] FN_NOT      = 5'd17;
	localparam logic [4:0] FN_AND      = 5'd18;
	localparam logic [4:0] FN_OR       = 5'd19;
	localparam logic [4:0] FN_XOR      = 5'd20;

	typedef struct packed {
		logic [4:0]              func;
		logic signed [Width-1:0] operand_a;
		logic signed [Width-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [Width-1:0] main_value;
		logic signed [Width-1:0] second_value;
		logic                    predicate_true;
		logic                    divide_by_zero;
	} rsp_t;

	// state carried down the pipeline
	typedef struct packed {
		logic [4:0]       func;
		logic [Width-1:0] b;
		logic             neg_a;
		logic             neg_b;
		logic             is_div;
		logic             dz;
		logic [Width-1:0] simple;
		logic             pred;
		logic [Width-1:0] mb;
		logic [Width-1:0] rem;
		logic [Width-1:0] quo;
	} pipe_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sia_front.sv =====
`default_nettype none
module sia_front import sia_pkg::*; (
	input  var req_t  req,
	output var pipe_t item
);
	logic [Width-1:0] a, b, ma, mb, shl, shr, fill;
	logic [Width:0]   nb;
	logic             neg_a, neg_b;

	always_comb begin
		a = req.operand_a;
		b = req.operand_b;
		neg_a = a[Width-1];
		neg_b = b[Width-1];
		ma = neg_a ? (~a + 1'b1) : a;
		mb = neg_b ? (~b + 1'b1) : b;
		nb = ~{neg_b, b} + 1'b1;
		fill = {Width{neg_a}};
		shl = ({1'b0, b} >= (Width+1)'(Width)) ? '0 : (a << b[ShW-1:0]);
		shr = (nb >= (Width+1)'(Width)) ? fill
			: Width'($signed(a) >>> nb[ShW-1:0]);

		item = '0;
		item.func = req.func;
		item.b = b;
		item.neg_a = neg_a;
		item.neg_b = neg_b;
		item.mb = mb;
		item.quo = ma;
		item.rem = '0;
		item.is_div = (req.func >= FN_DIV) && (req.func <= FN_QUOTIENT);
		item.dz = item.is_div && (b == '0);
		unique case (req.func)
			FN_LT:     item.pred = $signed(a) < $signed(b);
			FN_ODD:    item.pred = a[0];
			FN_EVEN:   item.pred = ~a[0];
			FN_ZERO:   item.pred = (a == '0);
			FN_POS:    item.pred = $signed(a) > $signed(Width'(0));
			FN_NEG:    item.pred = neg_a;
			FN_ABS:    item.simple = ma;
			FN_NEGATE: item.simple = ~a + 1'b1;
			FN_ADD:    item.simple = a + b;
			FN_SUB:    item.simple = a - b;
			FN_MUL:    item.simple = a * b;
			FN_ASH:    item.simple = (!neg_b && b != '0) ? shl : shr;
			FN_NOT:    item.simple = ~a;
			FN_AND:    item.simple = a & b;
			FN_OR:     item.simple = a | b;
			FN_XOR:    item.simple = a ^ b;
			default:   item.simple = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sia_div_step.sv =====
`default_nettype none
module sia_div_step import sia_pkg::*; (
	input  var pipe_t din,
	output var pipe_t dout
);
	logic [Width:0] t, d;

	// one restoring division bit
	always_comb begin
		t = {din.rem, din.quo[Width-1]};
		d = t - {1'b0, din.mb};
		dout = din;
		if (!d[Width]) begin
			dout.rem = d[Width-1:0];
			dout.quo = {din.quo[Width-2:0], 1'b1};
		end else begin
			dout.rem = t[Width-1:0];
			dout.quo = {din.quo[Width-2:0], 1'b0};
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sia_back.sv =====
`default_nettype none
module sia_back import sia_pkg::*; (
	input  var pipe_t din,
	output var rsp_t  rsp
);
	logic [Width-1:0] q, r, m;

	always_comb begin
		q = (din.neg_a != din.neg_b) ? (~din.quo + 1'b1) : din.quo;
		r = din.neg_a ? (~din.rem + 1'b1) : din.rem;
		m = (r != '0 && din.neg_a != din.neg_b) ? (r + din.b) : r;
		rsp = '0;
		if (din.is_div) begin
			rsp.divide_by_zero = din.dz;
			if (!din.dz) begin
				unique case (din.func)
					FN_MOD: rsp.main_value = m;
					FN_REM: rsp.main_value = r;
					FN_TRUNCDIV: begin
						rsp.main_value = q;
						rsp.second_value = r;
					end
					default: rsp.main_value = q;
				endcase
			end
		end else begin
			rsp.main_value = din.simple;
			rsp.predicate_true = din.pred;
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/signed_integer_alu.sv =====
`default_nettype none
// Pipelined 32-bit signed ALU with divide. One transaction enters per cycle unless the
// result side stalls. Each passes through one stage of decode, add, multiply and shift,
// one stage per quotient bit of the restoring divider, and one stage of sign correction
// feeding the output register. A stall on the result side holds the whole pipeline,
// so req_ready is low only while a result waits at the output.
module signed_integer_alu import sia_pkg::*; (
	input  var logic clk,
	input  var logic arst_n,
	input  var logic req_valid,
	output var logic req_ready,
	input  var req_t req,
	output var logic rsp_valid,
	input  var logic rsp_ready,
	output var rsp_t rsp
);
	localparam int Steps = Width;

	pipe_t item_c, item_s1;
	pipe_t step_c [Steps];
	pipe_t div_s2 [Steps];
	rsp_t  rsp_c, result_s3;
	logic  vld_s1;
	logic  vld_s2 [Steps];
	logic  vld_s3;
	logic  adv;

	assign adv = !vld_s3 || rsp_ready;
	assign req_ready = adv;

	sia_front u_front (.req(req), .item(item_c));

	for (genvar k = 0; k < Steps; k++) begin : g_div
		if (k == 0) begin : g_first
			sia_div_step u_step (.din(item_s1), .dout(step_c[k]));
		end else begin : g_next
			sia_div_step u_step (.din(div_s2[k-1]), .dout(step_c[k]));
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k] <= 1'b0;
			end else if (adv) begin
				vld_s2[k] <= (k == 0) ? vld_s1 : vld_s2[(k == 0) ? 0 : k-1];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s2[k] <= step_c[k];
			end
		end
	end

	sia_back u_back (.din(div_s2[Steps-1]), .rsp(rsp_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
			vld_s3 <= vld_s2[Steps-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item_c;
			result_s3 <= rsp_c;
		end
	end

	assign rsp_valid = vld_s3;
	assign rsp = result_s3;
endmodule
`default_nettype wire

// ===== hw/rtl/sia_checker.sv =====
`default_nettype none
module sia_checker import sia_pkg::*; (
	input var logic clk,
	input var logic arst_n,
	input var logic req_valid,
	input var logic req_ready,
	input var req_t req,
	input var logic rsp_valid,
	input var logic rsp_ready,
	input var rsp_t rsp
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input blocked with empty output");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.divide_by_zero |-> rsp.main_value == '0 && rsp.second_value == '0
			&& !rsp.predicate_true)
		else $error("divide by zero result not cleared");

	a_pred_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.predicate_true |-> rsp.main_value == '0 && rsp.second_value == '0)
		else $error("predicate with nonzero value");
endmodule

bind signed_integer_alu sia_checker u_sia_checker (.*);
`default_nettype wire

// ===== tb/sv/signed_integer_alu_checker.sv =====
module signed_integer_alu_checker import sia_pkg::*; (
	input  var logic clk,
	input  var logic arst_n,
	input  var logic req_valid,
	input  var logic req_ready,
	input  var req_t req,
	input  var logic rsp_valid,
	input  var logic rsp_ready,
	input  var rsp_t rsp,
	output int       errors,
	output int       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	rsp_t expected_rsps[$];

	function automatic rsp_t alu_result(req_t r);
		rsp_t o;
		logic signed [Width-1:0] a, b;
		logic [Width-1:0] ma, mb, uq, ur, q, rm;
		int n;
		o = '0;
		a = r.operand_a;
		b = r.operand_b;
		case (r.func)
			FN_LT: o.predicate_true = a < b;
			FN_ODD: o.predicate_true = a[0];
			FN_EVEN: o.predicate_true = !a[0];
			FN_ZERO: o.predicate_true = a == 0;
			FN_POS: o.predicate_true = a > 0;
			FN_NEG: o.predicate_true = a[Width-1];
			FN_ABS: o.main_value = a[Width-1] ? -a : a;
			FN_NEGATE: o.main_value = -a;
			FN_ADD: o.main_value = a + b;
			FN_SUB: o.main_value = a - b;
			FN_MUL: o.main_value = a * b;
			FN_DIV, FN_MOD, FN_REM, FN_TRUNCDIV, FN_QUOTIENT: begin
				if (b == 0) begin
					o.divide_by_zero = 1'b1;
				end else begin
					ma = a[Width-1] ? -a : a;
					mb = b[Width-1] ? -b : b;
					uq = ma / mb;
					ur = ma % mb;
					q = (a[Width-1] != b[Width-1]) ? -uq : uq;
					rm = a[Width-1] ? -ur : ur;
					case (r.func)
						FN_DIV, FN_QUOTIENT: o.main_value = q;
						FN_REM: o.main_value = rm;
						FN_MOD: o.main_value = (rm != 0 && a[Width-1] != b[Width-1]) ? rm + b : rm;
						default: begin
							o.main_value = q;
							o.second_value = rm;
						end
					endcase
				end
			end
			FN_ASH: begin
				if (b > 0) begin
					o.main_value = (b >= Width) ? '0 : a << b;
				end else if (b <= -Width) begin
					o.main_value = {Width{a[Width-1]}};
				end else begin
					n = -b;
					o.main_value = a >>> n;
				end
			end
			FN_NOT: o.main_value = ~a;
			FN_AND: o.main_value = a & b;
			FN_OR: o.main_value = a | b;
			FN_XOR: o.main_value = a ^ b;
			default: o = '0;
		endcase
		return o;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready)
				expected_rsps.push_back(alu_result(req));
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t unexpected transaction: actual %p", $time, rsp);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (want !== rsp) begin
						$display("%0t mismatch: expected %p actual %p", $time, want, rsp);
						errors++;
					end
				end
			end
			pending = expected_rsps.size();
		end
	end
endmodule

// ===== tb/sv/signed_integer_alu_test.sv =====
module signed_integer_alu_test import sia_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int errors, pending;
	int cycles = 0;
	bit stim_done = 1'b0;

	localparam int CycleLimit = 200000;

	always #2 clk = ~clk;

	signed_integer_alu dut (.*);

	signed_integer_alu_checker chk (.*);

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [Width-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '1;
			3: return '0;
			4: return $urandom_range(0, 40) - 20;
			5: return $urandom_range(0, 70) - 35;
			default: return $urandom();
		endcase
	endfunction

	// valid stays high into the next transaction when there is no gap
	task automatic send(logic [4:0] f, logic [Width-1:0] a, logic [Width-1:0] b);
		req_t r;
		int g;
		r.func = f;
		r.operand_a = a;
		r.operand_b = b;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	// receiver stalls, with stretches of full throughput
	initial begin
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) < 30) rsp_ready <= 1'b1;
			else begin
				rsp_ready <= 1'b0;
				repeat (gap_len() + 1) @(negedge clk);
				rsp_ready <= 1'b1;
				repeat ($urandom_range(0, 20)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [4:0] f;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		for (int i = 0; i <= FN_XOR; i++)
			send(i[4:0], 32'h8000_0000, '1);
		send(FN_DIV, 32'd7, 32'd0);
		send(FN_MOD, -32'sd7, 32'd2);
		send(FN_ASH, 32'h8000_0001, 32'd32);
		send(FN_ASH, 32'h8000_0001, -32'sd32);
		send(5'd31, '1, '1);
		for (int i = 0; i < 425; i++) begin
			f = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(21, 31))
				: 5'($urandom_range(0, 20));
			send(f, pick_value(), pick_value());
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
